/* rtl/csq_pkg.sv */
// Package with shared types and constants for the counting semaphore wait queue.
`timescale 1ns / 1ps

package csq_pkg;

  // Default configuration of the block.
  localparam int CsqQueueDepth = 16;
  localparam int CsqCountBits  = 16;

  // Field widths of the request and response.
  localparam int KindW  = 2;
  localparam int IdW    = 8;
  localparam int UnitsW = 16;

  // Request kinds. The remaining code is a no-op.
  typedef enum logic [KindW-1:0] {
    KIND_TRY    = 2'd0,
    KIND_WAIT   = 2'd1,
    KIND_NOTIFY = 2'd2
  } csq_kind_e;

  // Outcome flags of one request, handed from the core to the result stage.
  typedef struct packed {
    logic granted;
    logic queued;
    logic wake_valid;
    logic error_flag;
  } csq_flags_t;

endpackage

/* rtl/csq_intf.sv */
// Handshake interfaces for the request and response channels.
`timescale 1ns / 1ps

interface csq_req_if
  import csq_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [IdW-1:0]     requester_id;

  modport source (output valid, output kind, output requester_id, input ready);
  modport sink   (input valid, input kind, input requester_id, output ready);
endinterface

interface csq_rsp_if
  import csq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              granted;
  logic              queued;
  logic              wake_valid;
  logic [IdW-1:0]    wake_id;
  logic              error_flag;
  logic [UnitsW-1:0] units_left;

  modport source (
    output valid, output granted, output queued, output wake_valid,
    output wake_id, output error_flag, output units_left, input ready
  );
  modport sink (
    input valid, input granted, input queued, input wake_valid,
    input wake_id, input error_flag, input units_left, output ready
  );
endinterface

/* rtl/csq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module csq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/csq_core.sv */
// Semaphore count, queue pointers and per-request decision logic.
`timescale 1ns / 1ps

module csq_core
  import csq_pkg::*;
#(
  parameter int QUEUE_DEPTH = CsqQueueDepth,
  parameter int COUNT_BITS  = CsqCountBits,
  localparam int PtrW       = $clog2(QUEUE_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [UnitsW-1:0] cfg_wdata_i,
  input  logic              accept_i,
  input  logic [KindW-1:0]  kind_i,
  output csq_flags_t        flags_o,
  output logic [UnitsW-1:0] units_left_o,
  output logic              push_o,
  output logic [PtrW-1:0]   tail_o,
  output logic              pop_o,
  output logic [PtrW-1:0]   head_o
);

  localparam int FillW = $clog2(QUEUE_DEPTH + 1);
  localparam int CmpW  = (COUNT_BITS > UnitsW) ? COUNT_BITS : UnitsW;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [PtrW-1:0]       LastSlot = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [FillW-1:0]      FillMax  = FillW'(QUEUE_DEPTH);

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [PtrW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [FillW-1:0]      fill_q, fill_d;

  logic [CmpW-1:0]       cfg_ext, cmax_ext, cnt_next_ext;
  logic [COUNT_BITS-1:0] cfg_load;
  logic                  count_nz, count_full, queue_full, queue_empty;
  logic                  dec, inc;
  csq_flags_t            flags;

  // Clamp the written initial count to what the counter can hold.
  assign cfg_ext  = CmpW'(cfg_wdata_i);
  assign cmax_ext = CmpW'(CountMax);
  assign cfg_load = (cfg_ext > cmax_ext) ? CountMax : cfg_ext[COUNT_BITS-1:0];

  assign count_nz    = (count_q != '0);
  assign count_full  = (count_q == CountMax);
  assign queue_full  = (fill_q == FillMax);
  assign queue_empty = (fill_q == '0);

  // Decode the request against the current count and queue fill.
  always_comb begin
    flags  = '0;
    dec    = 1'b0;
    inc    = 1'b0;
    push_o = 1'b0;
    pop_o  = 1'b0;
    if (accept_i) begin
      unique case (csq_kind_e'(kind_i))
        KIND_TRY: begin
          if (count_nz) begin
            flags.granted = 1'b1;
            dec           = 1'b1;
          end
        end
        KIND_WAIT: begin
          if (count_nz) begin
            flags.granted = 1'b1;
            dec           = 1'b1;
          end else if (queue_full) begin
            flags.error_flag = 1'b1;
          end else begin
            flags.queued = 1'b1;
            push_o       = 1'b1;
          end
        end
        KIND_NOTIFY: begin
          if (!queue_empty) begin
            flags.wake_valid = 1'b1;
            pop_o            = 1'b1;
          end else if (count_full) begin
            flags.error_flag = 1'b1;
          end else begin
            inc = 1'b1;
          end
        end
        default: begin
          flags = '0;
        end
      endcase
    end
  end

  // Next values of the count and the queue pointers.
  always_comb begin
    count_d = count_q;
    if (cfg_we_i) begin
      count_d = cfg_load;
    end else if (dec) begin
      count_d = count_q - 1'b1;
    end else if (inc) begin
      count_d = count_q + 1'b1;
    end
    tail_d = push_o ? ((tail_q == LastSlot) ? '0 : tail_q + 1'b1) : tail_q;
    head_d = pop_o  ? ((head_q == LastSlot) ? '0 : head_q + 1'b1) : head_q;
    fill_d = fill_q;
    if (push_o) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_o) begin
      fill_d = fill_q - 1'b1;
    end
  end

  // Count and pointer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      fill_q  <= '0;
    end else begin
      count_q <= count_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
    end
  end

  // The reported count is the value after this request, low bits only.
  assign cnt_next_ext = CmpW'(count_d);
  assign units_left_o = cnt_next_ext[UnitsW-1:0];
  assign flags_o      = flags;
  assign tail_o       = tail_q;
  assign head_o       = head_q;

  // The fill level never passes the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FillMax)
    else $error("queue fill above depth");

  // One request never pushes and pops at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_o && pop_o))
    else $error("push and pop in the same cycle");

  // An empty queue has its head and tail on the same slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> (head_q == tail_q))
    else $error("empty queue with diverged pointers");

  // A pop lowers the fill by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (fill_q == $past(fill_q) - FillW'(1)))
    else $error("pop did not lower the fill");

endmodule

/* rtl/counting_semaphore_wait_queue.sv */
// Top level of the counting semaphore with a first-in first-out waiter queue.
//
//   Port         Direction  Contents
//   req_i        sink       kind, requester_id; valid/ready
//   rsp_o        source     granted, queued, wake_valid, wake_id, error_flag,
//                           units_left; valid/ready
//   cfg_we_i     in         write strobe of initial_count
//   cfg_wdata_i  in         initial_count value (16 bits)
//
// One request per cycle if no response stalls; its response shows next cycle.
// The count decision and a single queue push or pop are done in the accept
// cycle; the popped id comes from the queue RAM's registered read port.
// Reset clears the count to zero and empties the queue; there is no clearing
// pass. A stalled response holds and blocks new requests until it is taken.
`timescale 1ns / 1ps

module counting_semaphore_wait_queue
  import csq_pkg::*;
#(
  parameter int QUEUE_DEPTH = CsqQueueDepth,
  parameter int COUNT_BITS  = CsqCountBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [UnitsW-1:0] cfg_wdata_i,
  csq_req_if.sink           req_i,
  csq_rsp_if.source         rsp_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  logic              accept;
  logic              push, pop;
  logic [PtrW-1:0]   tail, head;
  logic [IdW-1:0]    rd_id;
  csq_flags_t        flags;
  logic [UnitsW-1:0] units_left;

  logic              rsp_valid_q;
  csq_flags_t        flags_q;
  logic [UnitsW-1:0] units_q;

  // A new request enters when the result register is free or being drained.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // Count and queue control.
  csq_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .COUNT_BITS  (COUNT_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .kind_i       (req_i.kind),
    .flags_o      (flags),
    .units_left_o (units_left),
    .push_o       (push),
    .tail_o       (tail),
    .pop_o        (pop),
    .head_o       (head)
  );

  // Waiter id storage; a pop reads the head entry into the read register.
  csq_ram #(
    .WIDTH (IdW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (tail),
    .wdata_i (req_i.requester_id),
    .re_i    (pop),
    .raddr_i (head),
    .rdata_o (rd_id)
  );

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      rsp_valid_q <= accept;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      flags_q <= flags;
      units_q <= units_left;
    end
  end

  // Response drive; the woken id shows only with a wake.
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.granted    = flags_q.granted;
  assign rsp_o.queued     = flags_q.queued;
  assign rsp_o.wake_valid = flags_q.wake_valid;
  assign rsp_o.wake_id    = flags_q.wake_valid ? rd_id : '0;
  assign rsp_o.error_flag = flags_q.error_flag;
  assign rsp_o.units_left = units_q;

endmodule

/* verif/counting_semaphore_wait_queue_checker.sv */
// Checker that predicts and compares every response of the semaphore wait queue.
`timescale 1ns / 1ps

module counting_semaphore_wait_queue_checker
  import csq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [UnitsW-1:0] cfg_wdata_i,
  csq_req_if                req_i,
  csq_rsp_if                rsp_i,
  output int                pending_o,
  output int                mismatches_o
);

  // One response as the block should report it.
  typedef struct packed {
    logic              granted;
    logic              queued;
    logic              wake_valid;
    logic [IdW-1:0]    wake_id;
    logic              error_flag;
    logic [UnitsW-1:0] units_left;
  } sem_outcome_t;

  // Predicted semaphore state: free units and the ids of blocked requesters.
  logic [CsqCountBits-1:0] sem_units;
  logic [IdW-1:0]          waiter_ids[$];
  sem_outcome_t            expected_outcomes[$];
  int                      mismatch_count;

  assign mismatches_o = mismatch_count;

  // Applies one request to the predicted state and returns its outcome.
  function automatic sem_outcome_t apply_request(logic [KindW-1:0] kind, logic [IdW-1:0] id);
    sem_outcome_t outcome;
    outcome = '0;
    if (kind == KIND_TRY || kind == KIND_WAIT) begin
      if (sem_units != '0) begin
        sem_units = sem_units - 1'b1;
        outcome.granted = 1'b1;
      end else if (kind == KIND_WAIT) begin
        // A full queue drops the waiter and flags the overflow.
        if (waiter_ids.size() >= CsqQueueDepth) begin
          outcome.error_flag = 1'b1;
        end else begin
          waiter_ids.insert(waiter_ids.size(), id);
          outcome.queued = 1'b1;
        end
      end
    end else if (kind == KIND_NOTIFY) begin
      // The oldest waiter gets the unit; otherwise the count rises and saturates.
      if (waiter_ids.size() > 0) begin
        outcome.wake_valid = 1'b1;
        outcome.wake_id    = waiter_ids[0];
        waiter_ids.delete(0);
      end else if (&sem_units) begin
        outcome.error_flag = 1'b1;
      end else begin
        sem_units = sem_units + 1'b1;
      end
    end
    outcome.units_left = UnitsW'(sem_units);
    return outcome;
  endfunction

  // Reports one field that differs from the prediction.
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: response field %s expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Samples both channels at each edge; responses are checked before new requests.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    sem_outcome_t want;
    if (!rst_ni) begin
      sem_units = '0;
      waiter_ids.delete();
      expected_outcomes.delete();
      mismatch_count = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        sem_units = CsqCountBits'(cfg_wdata_i);
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t ns: response arrived with no request outstanding, units_left %0d",
                   $time, rsp_i.units_left);
          mismatch_count++;
        end else begin
          want = expected_outcomes[0];
          expected_outcomes.delete(0);
          check_field("granted", want.granted, rsp_i.granted);
          check_field("queued", want.queued, rsp_i.queued);
          check_field("wake_valid", want.wake_valid, rsp_i.wake_valid);
          check_field("wake_id", want.wake_id, rsp_i.wake_id);
          check_field("error_flag", want.error_flag, rsp_i.error_flag);
          check_field("units_left", want.units_left, rsp_i.units_left);
        end
      end
      if (req_i.valid && req_i.ready) begin
        want = apply_request(req_i.kind, req_i.requester_id);
        expected_outcomes.insert(expected_outcomes.size(), want);
      end
      pending_o <= expected_outcomes.size();
    end
  end

endmodule

/* verif/counting_semaphore_wait_queue_tb.sv */
// Testbench top that drives requests and register writes and gives the verdict.
`timescale 1ns / 1ps

module counting_semaphore_wait_queue_tb;
  import csq_pkg::*;

  // The unused kind code, which must leave the state alone.
  localparam logic [KindW-1:0] KindNoop = 2'd3;
  localparam int StallLimit = 2000;
  localparam int PhaseItems = 210;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [UnitsW-1:0] cfg_wdata;
  int                pending;
  int                mismatches;

  csq_req_if req_if ();
  csq_rsp_if rsp_if ();

  counting_semaphore_wait_queue dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  counting_semaphore_wait_queue_checker checker_inst (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .pending_o   (pending),
    .mismatches_o(mismatches)
  );

  // Free-running clock, 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Offers one request and returns at the edge where it is accepted.
  task automatic push_request(logic [KindW-1:0] kind, logic [IdW-1:0] id);
    req_if.valid        <= 1'b1;
    req_if.kind         <= kind;
    req_if.requester_id <= id;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic idle_gap(int cycles);
    req_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops offering and waits until every predicted response has been taken.
  task automatic settle_all();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic load_initial_count(logic [UnitsW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Picks a request kind; the mode leans toward filling or draining the queue.
  function automatic logic [KindW-1:0] pick_kind(int mode);
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return KindNoop;
    case (mode)
      0: begin
        if (roll < 75) return KIND_WAIT;
        if (roll < 90) return KIND_NOTIFY;
        return KIND_TRY;
      end
      1: begin
        if (roll < 70) return KIND_NOTIFY;
        if (roll < 85) return KIND_WAIT;
        return KIND_TRY;
      end
      default: begin
        if (roll < 35) return KIND_WAIT;
        if (roll < 70) return KIND_NOTIFY;
        return KIND_TRY;
      end
    endcase
  endfunction

  // Request stimulus: reset, directed cases, then random phases per count setting.
  initial begin : stimulus
    logic [UnitsW-1:0] phase_counts[8];
    int                mode;
    int                burst_left;
    int                sent;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    req_if.valid        <= 1'b0;
    req_if.kind         <= KIND_TRY;
    req_if.requester_id <= '0;
    mode       = 0;
    burst_left = 0;
    sent       = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full count: notify saturates, then waits and try-waits take units.
    load_initial_count(16'hFFFF);
    push_request(KIND_NOTIFY, 8'h5A);
    push_request(KIND_TRY, 8'hFF);
    push_request(KIND_WAIT, 8'h00);
    settle_all();

    // Empty count: refused try-wait, no-op, count raise, then fill the queue past full.
    load_initial_count(16'h0000);
    push_request(KIND_TRY, 8'hFF);
    push_request(KindNoop, 8'hAA);
    push_request(KIND_NOTIFY, 8'h00);
    push_request(KIND_TRY, 8'h55);
    push_request(KIND_WAIT, 8'hFF);
    push_request(KIND_WAIT, 8'h00);
    for (int i = 2; i < CsqQueueDepth; i++) begin
      push_request(KIND_WAIT, IdW'(i * 17));
    end
    push_request(KIND_WAIT, 8'h81);
    push_request(KIND_NOTIFY, 8'hFF);
    settle_all();

    // Random phases; the queue carries over from one setting to the next.
    phase_counts = '{16'd0, 16'hFFFF, 16'd1, 16'd3, 16'd0, 16'd2, 16'hFFFE, 16'd0};
    phase_counts[4] = UnitsW'($urandom_range(65535));
    phase_counts[7] = UnitsW'($urandom_range(40));
    for (int ph = 0; ph < 8; ph++) begin
      load_initial_count(phase_counts[ph]);
      for (int n = 0; n < PhaseItems; n++) begin
        if (burst_left == 0) begin
          mode       = $urandom_range(2);
          burst_left = $urandom_range(8, 24);
        end
        burst_left--;
        push_request(pick_kind(mode), IdW'($urandom_range(255)));
        sent++;
        if (ph == 3 && n == PhaseItems / 2) begin
          settle_all();
        end else if ((sent < 600 || sent >= 900) && $urandom_range(99) < 7) begin
          idle_gap(1);
        end
      end
      settle_all();
    end

    repeat (5) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Response side: random back-pressure, a quiet stretch, and two long hold-offs.
  initial begin : drain
    int taken;
    int hold_left;
    int next_hold;
    taken     = 0;
    hold_left = 0;
    next_hold = 300;
    rsp_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) taken++;
      if (taken >= next_hold && hold_left == 0) begin
        hold_left = 80;
        next_hold = next_hold + 800;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (taken >= 500 && taken < 800) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= 7);
      end
    end
  end

  // Watchdog: too many cycles without any request or response moving ends the run.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || !rst_n) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule

/* sim.f */
rtl/csq_pkg.sv
rtl/csq_intf.sv
rtl/csq_ram.sv
rtl/csq_core.sv
rtl/counting_semaphore_wait_queue.sv
verif/counting_semaphore_wait_queue_checker.sv
verif/counting_semaphore_wait_queue_tb.sv
